// File: rtl/core/fir_filter_q31_mac_macros.svh
// Assertion macros for the fir_filter_q31_mac block.
// Included by the modules that check their own logic; no other dependencies.
`ifndef FIR_FILTER_Q31_MAC_MACROS_SVH
`define FIR_FILTER_Q31_MAC_MACROS_SVH
`ifndef SYNTHESIS
// A property that must hold at every rising clock edge outside reset.
`define FIR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// A condition that must never be true outside reset.
`define FIR_ASSERT_NEVER(label, clk, rst, cond, msg) \
   `FIR_ASSERT(label, clk, rst, !(cond), msg)
`else
`define FIR_ASSERT(label, clk, rst, prop, msg)
`define FIR_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// File: rtl/core/fir_q31_pkg.sv
// Shared types, constants and command structs of the Q1.31 FIR filter.
// Used by the controller, the datapath and the top level; depends on nothing else.
package fir_q31_pkg;

   // Filter length and the widths that follow from it.
   localparam int TAPS   = 1024;
   localparam int TAP_AW = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int CNT_W  = $clog2(TAPS + 1);
   localparam logic [31:0] TAPS_U32 = 32'(TAPS);
   localparam logic [TAP_AW-1:0] LAST_TAP = TAP_AW'(TAPS - 1);

   // Item kinds.
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_COEF   = 1'b1;

   // Configuration port layout.
   localparam int CSR_AW    = 3;
   localparam int REG_IDX_W = CSR_AW - 2;
   localparam logic [REG_IDX_W-1:0] REG_OUTPUT_SHIFT = '0;
   localparam logic [5:0] SHIFT_RESET = 6'd28;

   typedef struct packed {
      logic               kind;
      logic signed [31:0] sample_in;
      logic [9:0]         coef_index;
      logic signed [31:0] coef_value;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] sample_out;
      logic               saturated;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } fir_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              load_coef;
      logic              push_sample;
      logic              tap_issue;
      logic [TAP_AW-1:0] tap;
      logic              load_result;
   } fir_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic pipe_busy;
      logic out_free;
   } fir_status_type;

endpackage

// File: rtl/core/fir_q31_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the sample history and the coefficient store.
module fir_q31_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/fir_q31_ctrl.sv
// Controller of the FIR filter: accepts items and sequences the taps.
// Depends on fir_q31_pkg and the assertion macros header.
`include "fir_filter_q31_mac_macros.svh"
module fir_q31_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_kind,
   output logic                        req_stall,
   input  fir_q31_pkg::fir_status_type status,
   output fir_q31_pkg::fir_cmd_type    cmd
);
   import fir_q31_pkg::*;

   fir_state_type     state_ff, state_in;
   logic [TAP_AW-1:0] tap_ff, tap_in;
   logic              accept;

   // Items are taken only while no sample is in flight.
   assign accept = req_valid && !req_stall;

   // Next state and tap counter.
   always_comb begin
      state_in = state_ff;
      tap_in   = tap_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_kind == KIND_SAMPLE) begin
               state_in = ST_RUN;
               tap_in   = '0;
            end
         end
         ST_RUN: begin
            if (tap_ff == LAST_TAP) begin
               state_in = ST_DRAIN;
            end else begin
               tap_in = tap_ff + TAP_AW'(1);
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs to the handshake and the datapath.
   always_comb begin
      req_stall       = 1'b1;
      cmd.load_coef   = 1'b0;
      cmd.push_sample = 1'b0;
      cmd.tap_issue   = 1'b0;
      cmd.tap         = tap_ff;
      cmd.load_result = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall       = 1'b0;
            cmd.load_coef   = req_valid && req_kind == KIND_COEF;
            cmd.push_sample = req_valid && req_kind == KIND_SAMPLE;
         end
         ST_RUN: begin
            cmd.tap_issue = 1'b1;
         end
         ST_DRAIN: begin
         end
         ST_FINISH: begin
            cmd.load_result = status.out_free;
         end
         default: begin
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tap_ff   <= '0;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
      end
   end

   `FIR_ASSERT(a_sample_starts_run, clock, reset, (accept && req_kind == KIND_SAMPLE) |=> (state_ff == ST_RUN), "sample item did not start a run")
   `FIR_ASSERT(a_last_tap_drains, clock, reset, (state_ff == ST_RUN && tap_ff == LAST_TAP) |=> (state_ff == ST_DRAIN), "run did not end after the last tap")
   `FIR_ASSERT(a_finish_waits, clock, reset, (state_ff == ST_FINISH && !status.out_free) |=> (state_ff == ST_FINISH), "result dropped while output was full")

endmodule

// File: rtl/core/fir_q31_dp.sv
// Datapath of the FIR filter: history and coefficient memories, the
// multiply-accumulate pipeline, output shift, saturation and result register.
// Depends on fir_q31_pkg, fir_q31_ram and the assertion macros header.
`include "fir_filter_q31_mac_macros.svh"
module fir_q31_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  fir_q31_pkg::fir_cmd_type     cmd,
   input  fir_q31_pkg::req_payload_type req_data,
   input  logic [5:0]                   output_shift,
   output fir_q31_pkg::fir_status_type  status,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output fir_q31_pkg::rsp_payload_type rsp_data
);
   import fir_q31_pkg::*;

   logic [TAP_AW-1:0]   ptr_ff, ptr_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [TAP_AW:0]     slot_sum;
   logic [TAP_AW-1:0]   slot;
   logic [31:0]         cidx;
   logic                coef_wr;
   logic [31:0]         hist_rdata;
   logic [31:0]         coef_rdata;
   logic                rd_v_ff;
   logic                rd_live_ff;
   logic signed [31:0]  smp_s;
   logic signed [31:0]  cf_s;
   logic signed [63:0]  prod_in;
   logic signed [63:0]  prod_ff;
   logic                prod_v_ff;
   logic signed [63:0]  acc_ff;
   logic signed [63:0]  shifted;
   logic                sat;
   rsp_payload_type     result;
   rsp_payload_type     out_data_ff;
   logic                out_valid_ff;

   // Newest slot advances by one per sample; the fill count saturates at the
   // filter length, and taps older than the fill count read as zero.
   assign ptr_in = (ptr_ff == LAST_TAP) ? '0 : ptr_ff + TAP_AW'(1);
   assign cnt_in = (cnt_ff == CNT_W'(TAPS)) ? cnt_ff : cnt_ff + CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.push_sample) begin
         ptr_ff <= ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   // History slot of the tap being read, modulo the filter length.
   assign slot_sum = {1'b0, ptr_ff} + (TAP_AW + 1)'(TAPS) - {1'b0, cmd.tap};
   assign slot     = (ptr_ff >= cmd.tap) ? ptr_ff - cmd.tap : slot_sum[TAP_AW-1:0];

   // Coefficient writes outside the filter length are dropped.
   assign cidx    = 32'(req_data.coef_index);
   assign coef_wr = cmd.load_coef && (cidx < TAPS_U32);

   fir_q31_ram #(
      .WIDTH (32),
      .DEPTH (TAPS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (cmd.push_sample),
      .wr_addr (ptr_in),
      .wr_data (req_data.sample_in),
      .rd_addr (slot),
      .rd_data (hist_rdata)
   );

   fir_q31_ram #(
      .WIDTH (32),
      .DEPTH (TAPS)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_wr),
      .wr_addr (cidx[TAP_AW-1:0]),
      .wr_data (req_data.coef_value),
      .rd_addr (cmd.tap),
      .rd_data (coef_rdata)
   );

   // Read stage: track which read data is valid and holds a real sample.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff <= 1'b0;
      end else begin
         rd_v_ff <= cmd.tap_issue;
      end
   end

   always_ff @(posedge clock) begin
      rd_live_ff <= CNT_W'(cmd.tap) < cnt_ff;
   end

   // Multiply stage.
   assign smp_s   = rd_live_ff ? $signed(hist_rdata) : 32'sd0;
   assign cf_s    = $signed(coef_rdata);
   assign prod_in = smp_s * cf_s;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_v_ff <= 1'b0;
      end else begin
         prod_v_ff <= rd_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // Accumulate stage: 64-bit sum that wraps.
   always_ff @(posedge clock) begin
      if (cmd.push_sample) begin
         acc_ff <= '0;
      end else if (prod_v_ff) begin
         acc_ff <= acc_ff + prod_ff;
      end
   end

   // Output shift and saturation to the 32-bit signed range.
   assign shifted = acc_ff >>> output_shift;
   assign sat     = (shifted[63:31] != {33{1'b0}}) && (shifted[63:31] != {33{1'b1}});

   always_comb begin
      result.saturated = sat;
      priority if (!sat) begin
         result.sample_out = shifted[31:0];
      end else if (shifted[63]) begin
         result.sample_out = 32'sh8000_0000;
      end else begin
         result.sample_out = 32'sh7FFF_FFFF;
      end
   end

   // Result register; it frees up in the cycle its item is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_result) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_data         = out_data_ff;
   assign status.pipe_busy = rd_v_ff || prod_v_ff;
   assign status.out_free  = !out_valid_ff || !rsp_stall;

   `FIR_ASSERT(a_result_after_drain, clock, reset, cmd.load_result |-> (!rd_v_ff && !prod_v_ff), "result taken before the pipeline drained")
   `FIR_ASSERT(a_push_clears_acc, clock, reset, cmd.push_sample |=> (acc_ff == 64'sd0), "accumulator not cleared by a new sample")
   `FIR_ASSERT_NEVER(a_fill_in_range, clock, reset, cnt_ff > CNT_W'(TAPS), "fill count beyond filter length")

endmodule

// File: rtl/core/fir_filter_q31_mac.sv
// Top level of the Q1.31 direct-form FIR filter with its configuration port.
// Depends on fir_q31_pkg, fir_q31_ctrl and fir_q31_dp.
//
// A sample item is pushed into a 1024-entry history and filtered with one
// multiply-accumulate per tap per cycle through a single 32x32 multiplier and a
// 64-bit accumulator that wraps; the sum is shifted right arithmetically by
// output_shift (reset 28) and saturated to 32 bits, with saturated set when it
// clamps. No new item is taken until a sample is through: the taps are read in
// turn, the memory read, multiply and accumulate stages drain, the result is
// loaded and the controller returns to idle to accept. A finished result waits
// in an output register, so the next item is taken while it is still stalled.
// A coefficient write gives no result and is dropped when coef_index is not
// below the filter length. History entries never written since reset read as
// zero, with no clearing pass; every coefficient must be written before samples
// are sent.
// Change output_shift only while the block is idle.
module fir_filter_q31_mac (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  fir_q31_pkg::req_payload_type         req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output fir_q31_pkg::rsp_payload_type         rsp_data,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [fir_q31_pkg::CSR_AW-1:0]       csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);
   import fir_q31_pkg::*;

   fir_cmd_type          cmd;
   fir_status_type       status;
   logic [5:0]           shift_ff;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 csr_wr;

   // Configuration register: output shift at register index zero.
   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_AW-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= SHIFT_RESET;
      end else if (csr_wr && reg_idx == REG_OUTPUT_SHIFT) begin
         shift_ff <= csr_pwdata[5:0];
      end
   end

   assign csr_prdata = (reg_idx == REG_OUTPUT_SHIFT) ? {26'd0, shift_ff} : 32'd0;

   fir_q31_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fir_q31_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_data     (req_data),
      .output_shift (shift_ff),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule
